// ===== rtl/core/cgrt_pkg.sv =====
// ----------------------------------------------------------------------------
// cgrt_pkg
// Shared types and constants for the chunk grid ray walk.
// ----------------------------------------------------------------------------
package cgrt_pkg;

    // t cap, 10,000,000 in Q24.16
    localparam int unsigned TW = 40;
    localparam logic [TW-1:0] T_CAP = 40'd10000000 << 16;
    localparam int unsigned MAX_RES = 22;

    localparam logic [1:0] CFG_CHUNK_SIZE = 2'd0;
    localparam logic [1:0] CFG_REACH      = 2'd1;
    localparam logic [1:0] CFG_LAYERS     = 2'd2;

    // controller to datapath
    typedef struct packed {
        logic load;      // capture ray
        logic div_start; // start divider for one axis
        logic [1:0] axis;
        logic div_step;  // one divider iteration
        logic td_save;   // store quotient as t_delta
        logic mul_start;
        logic mul_save;  // store t_max after product divide
        logic walk;      // advance one chunk
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic div_done;
        logic outside;   // next step would leave the region
        logic start_bad;
    } t_sts;

endpackage

// ===== rtl/core/cgrt_datapath.sv =====
// ----------------------------------------------------------------------------
// cgrt_datapath
// Ray registers, a shared restoring divider and the DDA step logic.
// ----------------------------------------------------------------------------
module cgrt_datapath
    import cgrt_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    output t_sts               o_sts,
    input  logic [12:0]        i_chunk_size,
    input  logic [2:0]         i_reach,
    input  logic [3:0]         i_layers,
    input  logic signed [31:0] i_origin_x,
    input  logic signed [31:0] i_origin_y,
    input  logic signed [31:0] i_origin_z,
    input  logic signed [15:0] i_dir_x,
    input  logic signed [15:0] i_dir_y,
    input  logic signed [15:0] i_dir_z,
    input  logic signed [15:0] i_start_x,
    input  logic signed [15:0] i_start_y,
    input  logic signed [15:0] i_start_z,
    output logic signed [15:0] o_x,
    output logic signed [15:0] o_y,
    output logic signed [15:0] o_z
);

    // divider: 64-bit dividend, 43-bit divisor, one bit a cycle
    localparam int unsigned DW = 64;

    logic [31:0]        r_org [3];
    logic [15:0]        r_ad  [3];
    logic [1:0]         r_sg  [3];  // 0 zero, 1 plus, 2 minus
    logic [TW-1:0]      r_td  [3];
    logic [TW-1:0]      r_tm  [3];
    logic [12:0]        r_cs;
    logic signed [15:0] r_sx, r_sz, r_x, r_y, r_z;

    logic [DW-1:0] r_num;  // dividend shifting out / quotient shifting in
    logic [43:0]   r_rem;
    logic [42:0]   r_den;
    logic [6:0]    r_cnt;

    logic [20:0]   c_val;
    logic [31:0]   rem_r;
    logic [20:0]   rem_mod;
    logic [21:0]   frac;
    logic [TW-1:0] td_now;
    logic [43:0]   trial;
    logic [TW:0]   sum;
    logic          mv_x, mv_y;
    logic signed [15:0] ex, ez;
    logic signed [15:0] st_x, st_y, st_z;
    logic signed [15:0] n_x, n_y, n_z;
    logic [1:0]    ax;

    assign ax    = i_cmd.axis;
    assign c_val = {r_cs, 8'd0};
    // floor modulo by power-of-two-free C: use divider remainder instead
    assign rem_r = r_org[ax];
    assign trial = {r_rem[42:0], r_num[DW-1]} - {1'b0, r_den};

    // ray capture, restoring divide steps, t_delta and t_max save and walk step
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_org[0] <= i_origin_x; r_org[1] <= i_origin_y; r_org[2] <= i_origin_z;
            r_ad[0] <= i_dir_x[15] ? 16'(-i_dir_x) : 16'(i_dir_x);
            r_ad[1] <= i_dir_y[15] ? 16'(-i_dir_y) : 16'(i_dir_y);
            r_ad[2] <= i_dir_z[15] ? 16'(-i_dir_z) : 16'(i_dir_z);
            r_sg[0] <= (i_dir_x == 16'sd0) ? 2'd0 : (i_dir_x[15] ? 2'd2 : 2'd1);
            r_sg[1] <= (i_dir_y == 16'sd0) ? 2'd0 : (i_dir_y[15] ? 2'd2 : 2'd1);
            r_sg[2] <= (i_dir_z == 16'sd0) ? 2'd0 : (i_dir_z[15] ? 2'd2 : 2'd1);
            r_cs <= (i_chunk_size == 13'd0) ? 13'd1 : i_chunk_size;
            r_sx <= i_start_x; r_sz <= i_start_z;
            r_x <= i_start_x; r_y <= i_start_y; r_z <= i_start_z;
        end
        if (i_cmd.div_start) begin
            // first pass: magnitude of origin modulo C
            r_num <= {32'd0, rem_r[31] ? 32'(-rem_r) : rem_r};
            r_den <= {22'd0, c_val};
            r_rem <= '0;
            r_cnt <= 7'd0;
        end else if (i_cmd.mul_start) begin
            // second pass: t_delta quotient, then t_delta*frac/C
            r_num <= {37'd0, r_cs, 14'd0} << 16;
            r_den <= {27'd0, r_ad[ax]};
            r_rem <= '0;
            r_cnt <= 7'd0;
        end else if (i_cmd.td_save) begin
            r_td[ax] <= td_now;
            r_num <= 64'(td_now) * 64'(frac);
            r_den <= {22'd0, c_val};
            r_rem <= '0;
            r_cnt <= 7'd0;
        end else if (i_cmd.div_step) begin
            if (!trial[43]) begin
                r_rem <= trial;
                r_num <= {r_num[DW-2:0], 1'b1};
            end else begin
                r_rem <= {r_rem[42:0], r_num[DW-1]};
                r_num <= {r_num[DW-2:0], 1'b0};
            end
            r_cnt <= r_cnt + 7'd1;
        end
        if (i_cmd.mul_save) begin
            r_tm[ax] <= r_num[TW-1:0];
        end
        if (i_cmd.walk) begin
            if (mv_x) begin
                r_tm[0] <= sum[TW] || sum[TW-1:0] > T_CAP ? T_CAP : sum[TW-1:0];
            end else if (mv_y) begin
                r_tm[1] <= sum[TW] || sum[TW-1:0] > T_CAP ? T_CAP : sum[TW-1:0];
            end else begin
                r_tm[2] <= sum[TW] || sum[TW-1:0] > T_CAP ? T_CAP : sum[TW-1:0];
            end
            r_x <= n_x;
            r_y <= n_y;
            r_z <= n_z;
        end
    end

    // saved remainder of the modulo pass, folded to floor modulo for negative origins
    logic [20:0] r_mod;
    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_start) begin
            r_mod <= rem_mod;
        end
    end
    assign rem_mod = (r_org[ax][31] && r_rem[20:0] != 21'd0) ? c_val - r_rem[20:0]
                                                              : r_rem[20:0];

    assign td_now = (r_sg[ax] == 2'd0 || r_num > 64'(T_CAP)) ? T_CAP : r_num[TW-1:0];
    assign frac   = (r_sg[ax] == 2'd1) ? ({1'b0, c_val} - {1'b0, r_mod}) : {1'b0, r_mod};

    assign mv_x = (r_tm[0] < r_tm[1]) && (r_tm[0] < r_tm[2]);
    assign mv_y = !mv_x && (r_tm[1] < r_tm[2]);
    assign sum  = mv_x ? {1'b0, r_tm[0]} + {1'b0, r_td[0]}
                : mv_y ? {1'b0, r_tm[1]} + {1'b0, r_td[1]}
                :        {1'b0, r_tm[2]} + {1'b0, r_td[2]};

    // chunk reached by the next step
    assign st_x = (r_sg[0] == 2'd1) ? 16'sd1 : (r_sg[0] == 2'd2) ? -16'sd1 : 16'sd0;
    assign st_y = (r_sg[1] == 2'd1) ? 16'sd1 : (r_sg[1] == 2'd2) ? -16'sd1 : 16'sd0;
    assign st_z = (r_sg[2] == 2'd1) ? 16'sd1 : (r_sg[2] == 2'd2) ? -16'sd1 : 16'sd0;
    assign n_x  = mv_x ? r_x + st_x : r_x;
    assign n_y  = mv_y ? r_y + st_y : r_y;
    assign n_z  = (!mv_x && !mv_y) ? r_z + st_z : r_z;

    // distance from start stays small, so the wrapped 16-bit difference is exact
    assign ex = n_x - r_sx;
    assign ez = n_z - r_sz;
    assign o_sts.div_done  = (r_cnt == 7'(DW)) && i_rst_n;
    assign o_sts.outside   = (ex > 16'sd0 ? ex : -ex) > $signed({13'd0, i_reach})
                          || (ez > 16'sd0 ? ez : -ez) > $signed({13'd0, i_reach})
                          || n_y < 16'sd0 || n_y >= $signed({12'd0, i_layers});
    assign o_sts.start_bad = i_start_y < 16'sd0 || i_start_y >= $signed({12'd0, i_layers});
    assign o_x = r_x;
    assign o_y = r_y;
    assign o_z = r_z;

endmodule

// ===== rtl/core/cgrt_ctrl.sv =====
// ----------------------------------------------------------------------------
// cgrt_ctrl
// Sequencer: accept ray, run per-axis setup divides, walk and emit words.
// ----------------------------------------------------------------------------
module cgrt_ctrl
    import cgrt_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    output logic       o_valid,
    input  logic       i_ready,
    input  logic [2:0] i_reach,
    input  logic [3:0] i_layers,
    input  t_sts       i_sts,
    output t_cmd       o_cmd,
    output logic       o_valid_res,
    output logic       o_last,
    output logic       o_zero
);

    typedef enum logic [3:0] {
        S_IDLE, S_START, S_MOD, S_TDSTART, S_TD, S_MUL, S_NEXT, S_EMIT, S_WALK, S_CHECK,
        S_BAD
    } t_state;

    t_state     r_state;
    logic [1:0] r_axis;
    logic [4:0] r_n;
    logic [4:0] limit;
    logic [5:0] lim_w;

    assign lim_w = {2'd0, i_reach, 1'b0} + {2'd0, i_layers};
    assign limit = (lim_w > 6'(MAX_RES)) ? 5'(MAX_RES) : lim_w[4:0];

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = (r_state == S_EMIT) || (r_state == S_BAD);
    assign o_valid_res = (r_state == S_EMIT);
    assign o_zero = (r_state == S_BAD);
    assign o_last = (r_state == S_BAD) || (r_n + 5'd1 >= limit) || i_sts.outside;

    always_comb begin
        o_cmd = '0;
        o_cmd.axis = r_axis;
        case (r_state)
            S_IDLE:    o_cmd.load = i_valid;
            S_START:   o_cmd.div_start = 1'b1;
            S_MOD:     o_cmd.div_step = !i_sts.div_done;
            S_TDSTART: o_cmd.mul_start = 1'b1;
            S_TD:      begin
                o_cmd.div_step = !i_sts.div_done;
                o_cmd.td_save  = i_sts.div_done;
            end
            S_MUL:     begin
                o_cmd.div_step = !i_sts.div_done;
                o_cmd.mul_save = i_sts.div_done;
            end
            S_NEXT:    o_cmd.div_start = (r_axis != 2'd2);
            S_WALK:    o_cmd.walk = 1'b1;
            default:   o_cmd = '0;
        endcase
        if (r_state == S_NEXT) o_cmd.axis = r_axis + 2'd1;
    end

    // hold state and step counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_axis  <= 2'd0;
            r_n     <= 5'd0;
        end else begin
            case (r_state)
                S_IDLE: if (i_valid) begin
                    r_axis  <= 2'd0;
                    r_n     <= 5'd0;
                    r_state <= i_sts.start_bad ? S_BAD : S_START;
                end
                S_START:   r_state <= S_MOD;
                S_MOD:     if (i_sts.div_done) r_state <= S_TDSTART;
                S_TDSTART: r_state <= S_TD;
                S_TD:      if (i_sts.div_done) r_state <= S_MUL;
                S_MUL:     if (i_sts.div_done) r_state <= S_NEXT;
                S_NEXT:    if (r_axis == 2'd2) r_state <= S_EMIT;
                           else begin
                               r_axis  <= r_axis + 2'd1;
                               r_state <= S_MOD;
                           end
                S_EMIT: if (i_ready) begin
                    if (o_last) r_state <= S_IDLE;
                    else begin
                        r_n <= r_n + 5'd1;
                        r_state <= S_WALK;
                    end
                end
                S_WALK:  r_state <= S_CHECK;
                S_CHECK: r_state <= S_EMIT;
                S_BAD:   if (i_ready) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

// ===== rtl/core/chunk_grid_ray_traversal.sv =====
// ----------------------------------------------------------------------------
// chunk_grid_ray_traversal
// 3D DDA walk of a ray over the chunk grid, one chunk word per visited chunk.
// ----------------------------------------------------------------------------
// One ray is taken at a time. Setup runs three passes of a shared
// bit-serial divider per axis (origin modulo, t_delta, t_max), then each
// further chunk goes through the walk and check states and waits while
// the output stalls. A start layer outside the grid gives one invalid last word.
module chunk_grid_ray_traversal
    import cgrt_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_index,
    input  logic [12:0]        i_cfg_data,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic signed [31:0] i_origin_x,
    input  logic signed [31:0] i_origin_y,
    input  logic signed [31:0] i_origin_z,
    input  logic signed [15:0] i_dir_x,
    input  logic signed [15:0] i_dir_y,
    input  logic signed [15:0] i_dir_z,
    input  logic signed [15:0] i_start_x,
    input  logic signed [15:0] i_start_y,
    input  logic signed [15:0] i_start_z,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [15:0] o_chunk_x,
    output logic signed [15:0] o_chunk_y,
    output logic signed [15:0] o_chunk_z,
    output logic               o_valid_res,
    output logic               o_last
);

    logic [12:0] r_cs;
    logic [2:0]  r_reach;
    logic [3:0]  r_layers;
    t_cmd cmd;
    t_sts sts;
    logic zero;
    logic signed [15:0] x, y, z;

    // hold configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cs <= 13'd32; r_reach <= 3'd1; r_layers <= 4'd2;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_CHUNK_SIZE: r_cs <= i_cfg_data;
                CFG_REACH:      r_reach <= i_cfg_data[2:0];
                CFG_LAYERS:     r_layers <= i_cfg_data[3:0];
                default:        ;
            endcase
        end
    end

    cgrt_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .o_valid, .i_ready,
        .i_reach(r_reach), .i_layers(r_layers), .i_sts(sts), .o_cmd(cmd),
        .o_valid_res, .o_last, .o_zero(zero)
    );

    cgrt_datapath u_dp (
        .i_clk, .i_rst_n, .i_cmd(cmd), .o_sts(sts),
        .i_chunk_size(r_cs), .i_reach(r_reach), .i_layers(r_layers),
        .i_origin_x, .i_origin_y, .i_origin_z, .i_dir_x, .i_dir_y, .i_dir_z,
        .i_start_x, .i_start_y, .i_start_z, .o_x(x), .o_y(y), .o_z(z)
    );

    assign o_chunk_x = zero ? 16'sd0 : x;
    assign o_chunk_y = zero ? 16'sd0 : y;
    assign o_chunk_z = zero ? 16'sd0 : z;

    a_last_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_ready && o_last) |=> o_ready) else $error("no idle after last");
    a_bad_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_valid_res) |-> o_last) else $error("invalid word not last");
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_ready) else $error("ready while emitting");

endmodule
